/* sv/scd_pkg.sv */
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, constants and the microcode table of the serial command to
// character display sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

    localparam int MSG_LEN_DEF = 21;
    localparam int PC_W        = 6;
    localparam int LABEL_LEN   = 10;

    localparam logic [7:0] BYTE_D       = 8'h44;
    localparam logic [7:0] BYTE_F       = 8'h46;
    localparam logic [7:0] BYTE_HASH    = 8'h23;
    localparam logic [7:0] BYTE_PERCENT = 8'h25;
    localparam logic [7:0] CMD_LINE2    = 8'hC0;
    localparam logic [7:0] CMD_LINE1    = 8'h80;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_MSG  = 3'b010,
        MODE_FUEL = 3'b100
    } mode_t;

    typedef enum logic [2:0] {
        SEL_CONST,
        SEL_RX,
        SEL_DIG0,
        SEL_DIG1,
        SEL_PEND
    } sel_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SET_IDLE,
        ACT_SET_MSG,
        ACT_SET_FUEL,
        ACT_STORE_MSG,
        ACT_STORE_DIG,
        ACT_CLR_IDX,
        ACT_LOAD_PEND
    } act_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_MODE_MSG,
        COND_MODE_FUEL,
        COND_BYTE_D,
        COND_BYTE_F,
        COND_BYTE_HASH,
        COND_STORE_FULL,
        COND_CNT_LT2,
        COND_MSG_END
    } cond_t;

    typedef struct packed {
        logic            wait_in;
        logic            emit;
        sel_t            sel;
        logic [7:0]      cbyte;
        logic            is_char;
        logic            last;
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic mode_msg;
        logic mode_fuel;
        logic byte_d;
        logic byte_f;
        logic byte_hash;
        logic store_full;
        logic cnt_lt2;
        logic msg_end;
    } cond_flags_t;

    localparam logic [PC_W-1:0] S_FETCH    = 6'd0;
    localparam logic [PC_W-1:0] S_DISP_MSG = 6'd1;
    localparam logic [PC_W-1:0] S_DISP_FL  = 6'd2;
    localparam logic [PC_W-1:0] S_IDLE_D   = 6'd3;
    localparam logic [PC_W-1:0] S_IDLE_F   = 6'd4;
    localparam logic [PC_W-1:0] S_IDLE_END = 6'd5;
    localparam logic [PC_W-1:0] S_D_CMD    = 6'd6;
    localparam logic [PC_W-1:0] S_F_SET    = 6'd7;
    localparam logic [PC_W-1:0] S_MSG_IN   = 6'd8;
    localparam logic [PC_W-1:0] S_MSG_ST   = 6'd9;
    localparam logic [PC_W-1:0] S_MSG_RET  = 6'd10;
    localparam logic [PC_W-1:0] S_MSG_OUT  = 6'd11;
    localparam logic [PC_W-1:0] S_MSG_CHK  = 6'd12;
    localparam logic [PC_W-1:0] S_MSG_FST  = 6'd13;
    localparam logic [PC_W-1:0] S_MSG_LOOP = 6'd14;
    localparam logic [PC_W-1:0] S_MSG_NEXT = 6'd15;
    localparam logic [PC_W-1:0] S_MSG_LAST = 6'd16;
    localparam logic [PC_W-1:0] S_MSG_DONE = 6'd17;
    localparam logic [PC_W-1:0] S_FUEL_IN  = 6'd18;
    localparam logic [PC_W-1:0] S_F_CMD    = 6'd19;
    localparam logic [PC_W-1:0] S_LABEL    = 6'd20;
    localparam logic [PC_W-1:0] S_F_DIG0   = 6'd30;
    localparam logic [PC_W-1:0] S_F_DIG1   = 6'd31;
    localparam logic [PC_W-1:0] S_F_DIG2   = 6'd32;
    localparam logic [PC_W-1:0] S_F_PCT    = 6'd33;
    localparam logic [PC_W-1:0] S_DIG_ST   = 6'd34;
    localparam logic [PC_W-1:0] S_COUNT    = 6'd35;

    function automatic logic [7:0] label_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h46;
            4'd1:    c = 8'h55;
            4'd2:    c = 8'h45;
            4'd3:    c = 8'h6C;
            4'd4:    c = 8'h20;
            4'd5:    c = 8'h6C;
            4'd6:    c = 8'h76;
            4'd7:    c = 8'h6C;
            4'd8:    c = 8'h3A;
            4'd9:    c = 8'h20;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        logic [PC_W-1:0] lpos;
        lpos      = pc - S_LABEL;
        w         = '0;
        w.sel     = SEL_CONST;
        w.act     = ACT_NONE;
        w.cond    = COND_NEVER;
        w.target  = S_FETCH;
        case (pc)
            S_FETCH:    w.wait_in = 1'b1;
            S_DISP_MSG: begin w.cond = COND_MODE_MSG;  w.target = S_MSG_IN;  end
            S_DISP_FL:  begin w.cond = COND_MODE_FUEL; w.target = S_FUEL_IN; end
            S_IDLE_D:
            begin
                w.act    = ACT_SET_IDLE;
                w.cond   = COND_BYTE_D;
                w.target = S_D_CMD;
            end
            S_IDLE_F:   begin w.cond = COND_BYTE_F; w.target = S_F_SET; end
            S_IDLE_END: w.cond = COND_ALWAYS;
            S_D_CMD:
            begin
                w.emit  = 1'b1;
                w.cbyte = CMD_LINE2;
                w.last  = 1'b1;
                w.act   = ACT_SET_MSG;
                w.cond  = COND_ALWAYS;
            end
            S_F_SET:    begin w.act = ACT_SET_FUEL; w.cond = COND_ALWAYS; end
            S_MSG_IN:   begin w.cond = COND_BYTE_HASH; w.target = S_MSG_OUT; end
            S_MSG_ST:
            begin
                w.act    = ACT_STORE_MSG;
                w.cond   = COND_STORE_FULL;
                w.target = S_MSG_OUT;
            end
            S_MSG_RET:  w.cond = COND_ALWAYS;
            S_MSG_OUT:  w.act = ACT_CLR_IDX;
            S_MSG_CHK:  begin w.cond = COND_MSG_END; w.target = S_MSG_DONE; end
            S_MSG_FST:  w.act = ACT_LOAD_PEND;
            S_MSG_LOOP: begin w.cond = COND_MSG_END; w.target = S_MSG_LAST; end
            S_MSG_NEXT:
            begin
                w.emit    = 1'b1;
                w.sel     = SEL_PEND;
                w.is_char = 1'b1;
                w.act     = ACT_LOAD_PEND;
                w.cond    = COND_ALWAYS;
                w.target  = S_MSG_LOOP;
            end
            S_MSG_LAST:
            begin
                w.emit    = 1'b1;
                w.sel     = SEL_PEND;
                w.is_char = 1'b1;
                w.last    = 1'b1;
                w.act     = ACT_SET_IDLE;
                w.cond    = COND_ALWAYS;
            end
            S_MSG_DONE: begin w.act = ACT_SET_IDLE; w.cond = COND_ALWAYS; end
            S_FUEL_IN:  begin w.cond = COND_CNT_LT2; w.target = S_DIG_ST; end
            S_F_CMD:    begin w.emit = 1'b1; w.cbyte = CMD_LINE1; end
            6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29:
            begin
                w.emit    = 1'b1;
                w.cbyte   = label_char(lpos[3:0]);
                w.is_char = 1'b1;
            end
            S_F_DIG0:   begin w.emit = 1'b1; w.sel = SEL_DIG0; w.is_char = 1'b1; end
            S_F_DIG1:   begin w.emit = 1'b1; w.sel = SEL_DIG1; w.is_char = 1'b1; end
            S_F_DIG2:   begin w.emit = 1'b1; w.sel = SEL_RX;   w.is_char = 1'b1; end
            S_F_PCT:
            begin
                w.emit    = 1'b1;
                w.cbyte   = BYTE_PERCENT;
                w.is_char = 1'b1;
                w.last    = 1'b1;
                w.act     = ACT_SET_IDLE;
                w.cond    = COND_ALWAYS;
            end
            S_DIG_ST:   begin w.act = ACT_STORE_DIG; w.cond = COND_ALWAYS; end
            default:    w.cond = COND_ALWAYS;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/serial_command_to_char_display_top.sv */
// ----------------------------------------------------------------------------
// serial_command_to_char_display_top
// Turns received serial command bytes into character display writes.
//
//  channel  dir  tdata           tuser    tlast
//  s_axis   in   rx_byte[7:0]    -        -
//  m_axis   out  disp_byte[7:0]  is_char  last write of the input byte
//
// A received byte is taken only at the fetch step of the microcode.
// 'D' writes the line-2 cursor command; a message end or a full 21-character
// buffer writes the held characters up to the first zero byte; a fuel report
// writes the line-1 command, the label, its three digits and a percent sign.
// The pace is set by the one-step-per-cycle microcode sequencer when not stalled.
// rst_n clears mode, count, read index, output valid and the step counter;
// stores are not cleared. A stalled m_axis holds the sequencer at its next write step.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_to_char_display_top
    import scd_pkg::*;
#(
    parameter int MSG_LEN = MSG_LEN_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] disp_byte
    output logic            m_axis_tuser,   // [0] is_char
    output logic            m_axis_tlast
);

    localparam int CNT_W = ($clog2(MSG_LEN + 1) > 2) ? $clog2(MSG_LEN + 1) : 2;
    localparam int IDX_W = (MSG_LEN > 1) ? $clog2(MSG_LEN) : 1;

    ctrl_word_t       cw;
    cond_flags_t      flags;
    logic             go;
    logic             in_xfer;
    logic             out_busy;

    mode_t            mode_reg,  mode_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [CNT_W-1:0] idx_reg,   idx_next;
    logic [7:0]       rx_reg;
    logic [7:0]       pend_reg;
    logic [7:0]       msg_store_reg [MSG_LEN];
    logic [7:0]       dig_store_reg [2];
    logic [7:0]       rd_byte;
    logic [7:0]       emit_byte;
    logic             act_go;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_char_reg;
    logic             out_last_reg;

    assign s_axis_tready = cw.wait_in;
    assign in_xfer       = s_axis_tvalid && cw.wait_in;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign act_go        = go && !cw.wait_in;

    assign rd_byte = (idx_reg < CNT_W'(MSG_LEN)) ? msg_store_reg[idx_reg[IDX_W-1:0]] : 8'h00;

    always_comb
    begin
        flags.mode_msg   = (mode_reg == MODE_MSG);
        flags.mode_fuel  = (mode_reg == MODE_FUEL);
        flags.byte_d     = (rx_reg == BYTE_D);
        flags.byte_f     = (rx_reg == BYTE_F);
        flags.byte_hash  = (rx_reg == BYTE_HASH);
        flags.store_full = (cnt_reg == CNT_W'(MSG_LEN - 1));
        flags.cnt_lt2    = (cnt_reg < CNT_W'(2));
        flags.msg_end    = (idx_reg == cnt_reg) || (rd_byte == 8'h00);
    end

    scd_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .in_xfer  (in_xfer),
        .out_busy (out_busy),
        .cw       (cw),
        .go       (go)
    );

    always_comb
    begin
        case (cw.sel)
            SEL_CONST: emit_byte = cw.cbyte;
            SEL_RX:    emit_byte = rx_reg;
            SEL_DIG0:  emit_byte = dig_store_reg[0];
            SEL_DIG1:  emit_byte = dig_store_reg[1];
            SEL_PEND:  emit_byte = pend_reg;
            default:   emit_byte = cw.cbyte;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        if (act_go)
        begin
            case (cw.act)
                ACT_SET_IDLE:
                begin
                    mode_next = MODE_IDLE;
                    cnt_next  = '0;
                end
                ACT_SET_MSG:   mode_next = MODE_MSG;
                ACT_SET_FUEL:  mode_next = MODE_FUEL;
                ACT_STORE_MSG: cnt_next  = cnt_reg + 1'b1;
                ACT_STORE_DIG: cnt_next  = cnt_reg + 1'b1;
                ACT_CLR_IDX:   idx_next  = '0;
                ACT_LOAD_PEND: idx_next  = idx_reg + 1'b1;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            if (go && cw.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            rx_reg <= s_axis_tdata;
        end
        if (act_go && (cw.act == ACT_STORE_MSG))
        begin
            msg_store_reg[cnt_reg[IDX_W-1:0]] <= rx_reg;
        end
        if (act_go && (cw.act == ACT_STORE_DIG))
        begin
            dig_store_reg[cnt_reg[0]] <= rx_reg;
        end
        if (act_go && (cw.act == ACT_LOAD_PEND))
        begin
            pend_reg <= rd_byte;
        end
        if (go && cw.emit)
        begin
            out_byte_reg <= emit_byte;
            out_char_reg <= cw.is_char;
            out_last_reg <= cw.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        go && cw.emit |=> m_axis_tvalid)
        else $error("write step did not load the output register");

    a_fuel_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_FUEL) |-> cnt_reg <= CNT_W'(2))
        else $error("digit count out of range");

    a_msg_room: assert property (@(posedge clk) disable iff (!rst_n)
        cw.wait_in && (mode_reg == MODE_MSG) |-> cnt_reg < CNT_W'(MSG_LEN))
        else $error("message buffer full while waiting for a byte");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cw.wait_in && (mode_reg == MODE_IDLE) |-> cnt_reg == '0)
        else $error("count not cleared in idle");

endmodule

`default_nettype wire

/* sv/scd_useq.sv */
// ----------------------------------------------------------------------------
// scd_useq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_useq
    import scd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cond_flags_t flags,
    input  wire logic        in_xfer,
    input  wire logic        out_busy,
    output ctrl_word_t       cw,
    output logic             go
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign cw = ucode(pc_reg);
    assign go = !(cw.wait_in && !in_xfer) && !(cw.emit && out_busy);

    always_comb
    begin
        case (cw.cond)
            COND_NEVER:      taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_MODE_MSG:   taken = flags.mode_msg;
            COND_MODE_FUEL:  taken = flags.mode_fuel;
            COND_BYTE_D:     taken = flags.byte_d;
            COND_BYTE_F:     taken = flags.byte_f;
            COND_BYTE_HASH:  taken = flags.byte_hash;
            COND_STORE_FULL: taken = flags.store_full;
            COND_CNT_LT2:    taken = flags.cnt_lt2;
            COND_MSG_END:    taken = flags.msg_end;
            default:         taken = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (go)
        begin
            pc_next = taken ? cw.target : pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg < S_COUNT)
        else $error("step counter left the program");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> pc_reg == $past(pc_reg))
        else $error("step advanced while stalled");

    a_fetch_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == S_FETCH) && !in_xfer |=> pc_reg == S_FETCH)
        else $error("fetch step left without a transfer");

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial command to character display sequencer.
// Serial bytes go in on s_axis. Each transfer is run through a local model of
// the message, fuel report and idle modes. The model queues the display writes
// that the byte should cause. Every m_axis transfer is checked against the
// oldest queued write. A short directed table covers the special cases:
// empty messages, zero bytes, odd digits and ignored bytes. Random well-formed
// messages and fuel reports follow, mixed with noise. The run goes through
// four phases of sender and receiver idling.
// ----------------------------------------------------------------------------

module tb_top;

    import scd_pkg::*;

    localparam int MSG_LEN     = MSG_LEN_DEF;
    localparam int RAND_ITEMS  = 265;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int DIR_ROWS    = 24;
    localparam int MAX_SHOWN   = 40;

    localparam logic [8*LABEL_LEN-1:0] FUEL_TEXT = "FUEl lvl: ";

    typedef struct packed {
        logic [7:0] code;
        logic       is_char;
        logic       last;
    } disp_write_t;

    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        logic        one_write;
        disp_write_t write;
    } dir_row_t;

    localparam disp_write_t NO_WRITE = '0;
    localparam disp_write_t CURSOR2  = '{CMD_LINE2, 1'b0, 1'b1};

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'h00,     1'b1, 1'b0, NO_WRITE},
        '{8'hFF,     1'b1, 1'b0, NO_WRITE},
        '{BYTE_D,    1'b1, 1'b1, CURSOR2},
        '{BYTE_HASH, 1'b1, 1'b0, NO_WRITE},
        '{BYTE_D,    1'b1, 1'b1, CURSOR2},
        '{8'h00,     1'b0, 1'b0, NO_WRITE},
        '{8'h41,     1'b0, 1'b0, NO_WRITE},
        '{BYTE_HASH, 1'b1, 1'b0, NO_WRITE},
        '{BYTE_D,    1'b1, 1'b1, CURSOR2},
        '{8'h41,     1'b0, 1'b0, NO_WRITE},
        '{8'hFF,     1'b0, 1'b0, NO_WRITE},
        '{BYTE_F,    1'b0, 1'b0, NO_WRITE},
        '{8'h00,     1'b0, 1'b0, NO_WRITE},
        '{8'h42,     1'b0, 1'b0, NO_WRITE},
        '{BYTE_HASH, 1'b0, 1'b0, NO_WRITE},
        '{BYTE_F,    1'b1, 1'b0, NO_WRITE},
        '{8'h00,     1'b0, 1'b0, NO_WRITE},
        '{BYTE_HASH, 1'b0, 1'b0, NO_WRITE},
        '{BYTE_D,    1'b0, 1'b0, NO_WRITE},
        '{BYTE_F,    1'b1, 1'b0, NO_WRITE},
        '{8'hFF,     1'b0, 1'b0, NO_WRITE},
        '{BYTE_F,    1'b0, 1'b0, NO_WRITE},
        '{8'h80,     1'b0, 1'b0, NO_WRITE},
        '{BYTE_HASH, 1'b1, 1'b0, NO_WRITE}
    };

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] disp_byte
    logic       m_axis_tuser;            // [0] is_char
    logic       m_axis_tlast;

    // display model state
    mode_t      disp_mode  = MODE_IDLE;
    int         held_count = 0;
    logic [7:0] msg_buf [MSG_LEN];
    logic [7:0] digit_buf [2];

    disp_write_t pending_writes [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int writes_checked = 0;
    int active_bytes   = 0;
    int full_messages  = 0;
    int fuel_reports   = 0;

    serial_command_to_char_display_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("ERROR %0t: %s", $time, what);
    endtask

    task automatic queue_write(input logic [7:0] code, input logic is_char);
        disp_write_t w;
        w.code    = code;
        w.is_char = is_char;
        w.last    = 1'b0;
        pending_writes.push_back(w);
    endtask

    task automatic queue_message();
        int i;
        i = 0;
        while (i < held_count && msg_buf[i] != 8'h00)
        begin
            queue_write(msg_buf[i], 1'b1);
            i++;
        end
    endtask

    // Advance the model by one received byte and queue the writes it causes.
    task automatic predict_writes(input logic [7:0] rx, output bit ignored);
        int base;
        int i;
        base    = pending_writes.size();
        ignored = 1'b0;
        case (disp_mode)
            MODE_MSG:
            begin
                if (rx == BYTE_HASH)
                begin
                    queue_message();
                    disp_mode  = MODE_IDLE;
                    held_count = 0;
                end
                else
                begin
                    msg_buf[held_count] = rx;
                    held_count++;
                    if (held_count == MSG_LEN)
                    begin
                        full_messages++;
                        queue_message();
                        disp_mode  = MODE_IDLE;
                        held_count = 0;
                    end
                end
            end
            MODE_FUEL:
            begin
                if (held_count < 2)
                begin
                    digit_buf[held_count] = rx;
                    held_count++;
                end
                else
                begin
                    fuel_reports++;
                    queue_write(CMD_LINE1, 1'b0);
                    for (i = 0; i < LABEL_LEN; i++)
                        queue_write(FUEL_TEXT[8*(LABEL_LEN-1-i) +: 8], 1'b1);
                    queue_write(digit_buf[0], 1'b1);
                    queue_write(digit_buf[1], 1'b1);
                    queue_write(rx, 1'b1);
                    queue_write(BYTE_PERCENT, 1'b1);
                    disp_mode  = MODE_IDLE;
                    held_count = 0;
                end
            end
            default:
            begin
                held_count = 0;
                if (rx == BYTE_D)
                begin
                    queue_write(CMD_LINE2, 1'b0);
                    disp_mode = MODE_MSG;
                end
                else if (rx == BYTE_F)
                    disp_mode = MODE_FUEL;
                else
                    ignored = 1'b1;
            end
        endcase
        if (pending_writes.size() > base)
            pending_writes[pending_writes.size()-1].last = 1'b1;
    endtask

    // Drive one byte, wait for its transfer, then queue its writes.
    // A typed row replaces the model's writes with the ones given in the table.
    task automatic send_byte(input logic [7:0] rx, input logic typed,
                             input logic one_write, input disp_write_t w);
        bit ignored;
        int base;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_axis_tready);
        base = pending_writes.size();
        predict_writes(rx, ignored);
        if (!ignored)
            active_bytes++;
        if (typed)
        begin
            while (pending_writes.size() > base)
                void'(pending_writes.pop_back());
            if (one_write)
                pending_writes.push_back(w);
        end
    endtask

    task automatic push_rx(input logic [7:0] rx);
        send_byte(rx, 1'b0, 1'b0, NO_WRITE);
    endtask

    function automatic logic [7:0] random_payload(input bit allow_hash);
        logic [7:0] r;
        case ($urandom_range(15))
            0:       r = 8'h00;
            1:       r = BYTE_D;
            2:       r = BYTE_F;
            3:       r = BYTE_HASH;
            4, 5, 6: r = 8'h30 + 8'($urandom_range(9));
            default: r = 8'($urandom_range(255));
        endcase
        if (!allow_hash && r == BYTE_HASH)
            r = 8'h2A;
        return r;
    endfunction

    task automatic check_write();
        disp_write_t want;
        if (pending_writes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected write %02h is_char %0b last %0b",
                                      m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end
        else
        begin
            want = pending_writes.pop_front();
            writes_checked++;
            if (m_axis_tdata !== want.code)
                report_mismatch($sformatf("disp_byte %02h, want %02h",
                                          m_axis_tdata, want.code));
            if (m_axis_tuser !== want.is_char)
                report_mismatch($sformatf("is_char %0b, want %0b on byte %02h",
                                          m_axis_tuser, want.is_char, want.code));
            if (m_axis_tlast !== want.last)
                report_mismatch($sformatf("last %0b, want %0b on byte %02h",
                                          m_axis_tlast, want.last, want.code));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_write();
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        int len;
        int pick;
        int phase;
        int next_phase;
        int rand_base;
        bit first_seq;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_byte(DIR_TABLE[k].rx, DIR_TABLE[k].typed,
                      DIR_TABLE[k].one_write, DIR_TABLE[k].write);

        rand_base = active_bytes;
        phase     = 0;
        first_seq = 1'b1;
        while (active_bytes - rand_base < RAND_ITEMS)
        begin
            next_phase = (active_bytes - rand_base) * 4 / RAND_ITEMS;
            if (next_phase != phase)
            begin
                // hold the sender until every queued write is out
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_writes.size() != 0);
                phase          = next_phase;
                send_idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 37 : 0;
                recv_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 37 : 0;
            end
            pick = $urandom_range(99);
            if (first_seq || pick < 40)
            begin
                push_rx(BYTE_D);
                len = (first_seq || $urandom_range(3) == 0) ? MSG_LEN
                                                           : $urandom_range(MSG_LEN - 1);
                for (k = 0; k < len; k++)
                    push_rx(random_payload(1'b0));
                if (len < MSG_LEN)
                    push_rx(BYTE_HASH);
            end
            else if (pick < 75)
            begin
                push_rx(BYTE_F);
                for (k = 0; k < 3; k++)
                    push_rx(random_payload(1'b1));
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    push_rx(random_payload(1'b1));
            end
            first_seq = 1'b0;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d table rows and %0d further non-ignored bytes; checked %0d writes",
                 DIR_ROWS, active_bytes - rand_base, writes_checked);
        $display("Full-buffer messages: %0d, fuel reports: %0d, mismatches: %0d",
                 full_messages, fuel_reports, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/scd_pkg.sv
sv/scd_useq.sv
sv/serial_command_to_char_display_top.sv
tb/sv/tb_top.sv
